// ===== src/matrix3_inverse_top_assert.svh =====
// Assertion macros shared by the matrix inverse block.
// M3I_ASSERT checks on the rising clock edge outside reset.
// M3I_ASSERT_RST checks on the rising clock edge, reset included.
`ifndef MATRIX3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define M3I_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("m3i assertion failed");
`define M3I_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("m3i assertion failed");
`else
`define M3I_ASSERT(lbl, prop)
`define M3I_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== src/m3i_pkg.sv =====
package m3i_pkg;
	// matrix elements per item
	localparam int NELEM = 9;
	// singular threshold register
	localparam int THR_W = 31;
	localparam logic [THR_W-1:0] THR_RESET = 31'd7;
endpackage

// ===== src/matrix3_inverse_top.sv =====
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 by default).
// Input channel s_*: one item is a row-major matrix, m00 in the lowest bits of
// s_tdata. Output channel m_*: the inverse r00..r22 in m_tdata, same order,
// and the singular flag in m_tuser. Results are rounded to nearest (ties away
// from zero) and clamped to the signed range; a matrix whose determinant
// magnitude is not above the threshold comes out as the identity with the
// flag set. The threshold is written through cfg_valid/cfg_data (always
// ready) and must only change while no item is in flight.
// Path from input accept to m_tvalid: the cofactor and determinant
// product stages, then nine divider lanes with one quotient bit per
// stage, then the output stage. Throughput: one item per cycle while the
// output does not stall; the lane dividers are fully pipelined.
// Stall: when the output item is not taken and the last pipeline stage is
// full, the whole pipeline holds and s_tready drops; an empty last stage
// still lets the pipeline advance. Reset clears the valid bits and the
// output valid flag and sets the threshold to 7.
module matrix3_inverse_top
	import m3i_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	localparam int TDW = ((NELEM * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data,   // singular_threshold
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [TDW-1:0]   s_tdata,    // m00, m01, m02, m10, m11, m12, m20, m21, m22
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [TDW-1:0]   m_tdata,    // r00, r01, r02, r10, r11, r12, r20, r21, r22
	output logic             m_tuser     // singular
);
	`include "matrix3_inverse_top_assert.svh"

	localparam int W   = DATA_WIDTH;
	localparam int CW  = 2 * W + 1;
	localparam int DTW = 3 * W + 3;
	// front end 4 stages, lane W + 3 stages
	localparam int L   = W + 7;
	localparam int SDL = W + 2;
	localparam logic [W-1:0] ONE = (FRAC_BITS >= W - 1) ?
		((W'(1) << (W - 1)) - 1'b1) : (W'(1) << FRAC_BITS);

	logic [THR_W-1:0]     thr_q;
	logic [L-1:0]         vld_q;
	logic                 en;
	logic                 out_take;
	logic signed [W-1:0]  mat [NELEM];
	logic signed [CW-1:0] adj [NELEM];
	logic signed [DTW-1:0] det;
	logic                 sing;
	logic                 sing_dl [SDL];
	logic [W-1:0]         lres [NELEM];
	logic [W-1:0]         mres [NELEM];
	logic [TDW-1:0]       mpack;
	logic                 out_vld_q;
	logic [TDW-1:0]       out_data_q;
	logic                 out_sing_q;

	// threshold register; the user must write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// advance unless the last stage holds an item the output cannot take
	assign out_take = !out_vld_q || m_tready;
	assign en       = out_take || !vld_q[L-1];
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], s_tvalid};
		end
	end

	for (genvar k = 0; k < NELEM; k++) begin : g_unpack
		assign mat[k] = s_tdata[k*W +: W];
	end

	m3i_cof #(.W(W), .F(FRAC_BITS)) u_cof (
		.clk  (clk),
		.en   (en),
		.mat  (mat),
		.thr  (thr_q),
		.adj  (adj),
		.det  (det),
		.sing (sing)
	);

	// nine divider lanes, one per element
	for (genvar k = 0; k < NELEM; k++) begin : g_lane
		m3i_lane #(.W(W), .F(FRAC_BITS)) u_lane (
			.clk (clk),
			.en  (en),
			.cof (adj[k]),
			.det (det),
			.res (lres[k])
		);
	end

	// align the singular flag with the lane results
	always_ff @(posedge clk) begin
		if (en) begin
			sing_dl[0] <= sing;
			for (int i = 1; i < SDL; i++) begin
				sing_dl[i] <= sing_dl[i-1];
			end
		end
	end

	// merge: identity when singular, lane quotients otherwise
	for (genvar k = 0; k < NELEM; k++) begin : g_merge
		localparam bit DIAG = (k == 0) || (k == 4) || (k == 8);
		assign mres[k] = sing_dl[SDL-1] ? (DIAG ? ONE : '0) : lres[k];
	end

	// pack the nine elements, zero fill above them
	always_comb begin
		mpack = '0;
		for (int k = 0; k < NELEM; k++) begin
			mpack[k*W +: W] = mres[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_take) begin
			out_vld_q <= vld_q[L-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_take && vld_q[L-1]) begin
			out_data_q <= mpack;
			out_sing_q <= sing_dl[SDL-1];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_sing_q;

	`M3I_ASSERT(a_sing_diag, (m_tvalid && m_tuser) |-> (m_tdata[0 +: W] == ONE && m_tdata[4*W +: W] == ONE && m_tdata[8*W +: W] == ONE && m_tdata[W +: W] == '0))
	`M3I_ASSERT(a_freeze, (vld_q[L-1] && out_vld_q && !m_tready) |-> !s_tready)
	`M3I_ASSERT(a_enter, (s_tvalid && s_tready) |=> vld_q[0])
	`M3I_ASSERT(a_hold, !en |=> $stable(vld_q))
	`M3I_ASSERT_RST(a_rst_out, !arst_n |=> !m_tvalid)
endmodule

// ===== src/m3i_cof.sv =====
module m3i_cof
	import m3i_pkg::*;
#(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [W-1:0]     mat [NELEM],
	input  logic [THR_W-1:0]        thr,
	output logic signed [2*W:0]     adj [NELEM],
	output logic signed [3*W+2:0]   det,
	output logic                    sing
);
	localparam int CW   = 2 * W + 1;
	localparam int PW   = 2 * W;
	localparam int DTW  = 3 * W + 3;
	localparam int CMPW = DTW + THR_W + 2 * F;

	// cofactor k = m[AX]*m[AY] - m[BX]*m[BY], signs folded into the order
	localparam int AX [NELEM] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
	localparam int AY [NELEM] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
	localparam int BX [NELEM] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
	localparam int BY [NELEM] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

	logic signed [PW-1:0]  pa_s1 [NELEM];
	logic signed [PW-1:0]  pb_s1 [NELEM];
	logic signed [W-1:0]   mrow_s1 [3];
	logic signed [CW-1:0]  adj_s2 [NELEM];
	logic signed [W-1:0]   mrow_s2 [3];
	logic signed [CW-1:0]  adj_s3 [NELEM];
	logic signed [CW-1:0]  lo_s3 [3];
	logic signed [CW-1:0]  hi_s3 [3];
	logic signed [DTW-1:0] term [3];
	logic signed [CW-1:0]  adj_s4 [NELEM];
	logic signed [DTW-1:0] det_s4;
	logic [DTW-1:0]        dmag;
	logic                  sing_s5;

	for (genvar k = 0; k < NELEM; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[k]  <= mat[AX[k]] * mat[AY[k]];
				pb_s1[k]  <= mat[BX[k]] * mat[BY[k]];
				adj_s2[k] <= CW'(pa_s1[k]) - CW'(pb_s1[k]);
				adj_s3[k] <= adj_s2[k];
				adj_s4[k] <= adj_s3[k];
			end
		end
	end

	// det = m0*adj0 + m1*adj3 + m2*adj6, each product split in low and high halves
	for (genvar j = 0; j < 3; j++) begin : g_det
		always_ff @(posedge clk) begin
			if (en) begin
				mrow_s1[j] <= mat[j];
				mrow_s2[j] <= mrow_s1[j];
				lo_s3[j]   <= mrow_s2[j] * $signed({1'b0, adj_s2[3*j][W-1:0]});
				hi_s3[j]   <= mrow_s2[j] * $signed(adj_s2[3*j][CW-1:W]);
			end
		end
		assign term[j] = (DTW'(hi_s3[j]) <<< W) + DTW'(lo_s3[j]);
	end

	assign dmag = det_s4[DTW-1] ? (~det_s4 + 1'b1) : det_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4  <= term[0] + term[1] + term[2];
			sing_s5 <= !(CMPW'(dmag) > (CMPW'(thr) << (2 * F)));
		end
	end

	assign adj  = adj_s4;
	assign det  = det_s4;
	assign sing = sing_s5;
endmodule

// ===== src/m3i_lane.sv =====
module m3i_lane
	import m3i_pkg::*;
#(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [2*W:0]   cof,
	input  logic signed [3*W+2:0] det,
	output logic [W-1:0]          res
);
	localparam int CW  = 2 * W + 1;
	localparam int DTW = 3 * W + 3;
	localparam int NW  = CW + 2 * F;
	localparam int DSW = DTW + W;
	localparam int RW  = (NW > DSW) ? NW : DSW;
	localparam int NST = W + 1;

	logic [CW-1:0]  cmag;
	logic [DTW-1:0] dmag;
	logic [RW-1:0]  num_s1;
	logic [DTW-1:0] div_s1;
	logic           neg_s1;

	logic [RW-1:0]  rem_sk [NST];
	logic [W-1:0]   quo_sk [NST];
	logic [DTW-1:0] dv_sk [NST];
	logic           neg_sk [NST];
	logic           ovf_sk [NST];

	logic           rnd;
	logic [W:0]     qr;
	logic [W:0]     lim;
	logic [W:0]     qs;
	logic [W:0]     qn;
	logic [W-1:0]   res_q;

	assign cmag = cof[CW-1] ? (~cof + 1'b1) : cof;
	assign dmag = det[DTW-1] ? (~det + 1'b1) : det;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1    <= RW'(cmag) << (2 * F);
			div_s1    <= dmag;
			neg_s1    <= cof[CW-1] ^ det[DTW-1];
			rem_sk[0] <= num_s1;
			quo_sk[0] <= '0;
			dv_sk[0]  <= div_s1;
			neg_sk[0] <= neg_s1;
			ovf_sk[0] <= num_s1 >= (RW'(div_s1) << W);
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < W; k++) begin : g_step
		localparam int B = W - 1 - k;
		logic [RW-1:0] sh;
		assign sh = RW'(dv_sk[k]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_sk[k] >= sh) begin
					rem_sk[k+1] <= rem_sk[k] - sh;
					quo_sk[k+1] <= quo_sk[k] | (W'(1) << B);
				end else begin
					rem_sk[k+1] <= rem_sk[k];
					quo_sk[k+1] <= quo_sk[k];
				end
				dv_sk[k+1]  <= dv_sk[k];
				neg_sk[k+1] <= neg_sk[k];
				ovf_sk[k+1] <= ovf_sk[k];
			end
		end
	end

	// round half away from zero, clamp, apply sign
	always_comb begin
		rnd = {rem_sk[W], 1'b0} >= (RW+1)'(dv_sk[W]);
		qr  = {1'b0, quo_sk[W]} + (W+1)'(rnd);
		lim = neg_sk[W] ? ((W+1)'(1) << (W - 1)) : (((W+1)'(1) << (W - 1)) - 1'b1);
		qs  = (ovf_sk[W] || (qr > lim)) ? lim : qr;
		qn  = neg_sk[W] ? ((W+1)'(0) - qs) : qs;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= qn[W-1:0];
		end
	end

	assign res = res_q;
endmodule
